### sv/acfm_pkg.sv
// acfm_pkg: shared widths, constants and the word types that travel along the
// cell chain of the adaptive cumulative frequency model.
// No dependencies.
package acfm_pkg;

    // number of coded symbols; the table has one more entry
    localparam int NUM_SYMBOLS = 257;
    localparam int TAB_LEN     = NUM_SYMBOLS + 1;

    // field widths
    localparam int TAB_W = 16;
    localparam int SYM_W = 9;
    localparam int IDX_W = $clog2(TAB_LEN);

    // compare width: room for the larger of symbol and index plus one
    localparam int CMP_W = ((IDX_W > SYM_W) ? IDX_W : SYM_W) + 1;

    // reset value of the max_total register
    localparam logic [TAB_W-1:0] MAX_TOTAL_RST = 16'd16383;

    // one word in flight along the chain, from the top cell down to cell zero
    typedef struct packed {
        logic             valid;
        logic             act;    // symbol in range, table gets updated
        logic             resc;   // this word halves all counts
        logic [SYM_W-1:0] sym;
        logic [TAB_W-1:0] acc;    // running sum of halved counts
        logic [TAB_W-1:0] hi;
        logic [TAB_W-1:0] lo;
        logic [TAB_W-1:0] tot;
    } wave_t;

    // report from cell zero when a halving pass has finished
    typedef struct packed {
        logic             valid;
        logic [TAB_W-1:0] total;
    } retire_t;

endpackage

### sv/acfm_cell.sv
// acfm_cell: one table entry of the cumulative frequency chain with its stage
// of the word pipeline. Depends on acfm_pkg.
module acfm_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic [acfm_pkg::IDX_W-1:0] cell_idx,
    input  acfm_pkg::wave_t        wave_i,
    input  logic [acfm_pkg::TAB_W-1:0] below_next,
    output acfm_pkg::wave_t        wave_o,
    output logic [acfm_pkg::TAB_W-1:0] cnt_next_o
);
    import acfm_pkg::*;

    logic [TAB_W-1:0] cnt_reg, cnt_next;
    wave_t            wave_reg, wave_next;
    logic [CMP_W-1:0] sym_x, idx_x;
    logic             inc, lo_hit, hi_hit;
    logic [TAB_W-1:0] base, freq, half;
    logic [TAB_W:0]   freq_up;

    // position of this cell against the symbol of the passing word
    always_comb begin
        sym_x  = CMP_W'(wave_i.sym);
        idx_x  = CMP_W'(cell_idx);
        inc    = idx_x < sym_x;
        lo_hit = wave_i.act && (sym_x == idx_x);
        hi_hit = wave_i.act && (sym_x == idx_x + CMP_W'(1));
    end

    // halved count of the symbol between this entry and the one below
    always_comb begin
        freq    = below_next - cnt_reg;
        freq_up = {1'b0, freq} + (TAB_W+1)'(1);
        half    = freq_up[TAB_W:1];
    end

    // entry update: rebuild from the sum when halving, then count the symbol
    always_comb begin
        base     = wave_i.resc ? wave_i.acc : cnt_reg;
        cnt_next = cnt_reg;
        if (advance && wave_i.valid && wave_i.act) begin
            cnt_next = base + TAB_W'(inc);
        end
    end

    // outgoing word: captured bounds and the grown sum
    always_comb begin
        wave_next     = wave_i;
        wave_next.acc = wave_i.acc + half;
        if (lo_hit) begin
            wave_next.lo = cnt_reg;
        end
        if (hi_hit) begin
            wave_next.hi = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= TAB_W'(NUM_SYMBOLS) - TAB_W'(cell_idx);
            wave_reg <= '0;
        end else if (advance) begin
            cnt_reg  <= cnt_next;
            wave_reg <= wave_next;
        end
    end

    assign wave_o     = wave_reg;
    assign cnt_next_o = cnt_next;

endmodule

### sv/acfm_head.sv
// acfm_head: input acceptance, max_total register and the running total that
// decides halving. Depends on acfm_pkg.
module acfm_head (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [acfm_pkg::SYM_W-1:0] s_symbol,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [acfm_pkg::TAB_W-1:0] cfg_data,
    input  logic                   advance,
    input  acfm_pkg::retire_t      retire,
    output acfm_pkg::wave_t        wave_o
);
    import acfm_pkg::*;

    logic [TAB_W-1:0] max_reg;
    logic [TAB_W-1:0] total_reg, total_next;
    logic             pend_reg, pend_next;
    logic             accept, act, resc;

    // accept only while the chain moves and no halving pass is in flight
    assign s_ready   = advance && !pend_reg;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign act  = (s_symbol != '0) && (CMP_W'(s_symbol) <= CMP_W'(NUM_SYMBOLS));
    assign resc = act && (total_reg >= max_reg);

    // new word entering the top cell
    always_comb begin
        wave_o       = '0;
        wave_o.valid = accept;
        wave_o.act   = act;
        wave_o.resc  = resc;
        wave_o.sym   = s_symbol;
        wave_o.tot   = total_reg;
    end

    // total tracking: plus one per counted symbol, reload after halving
    always_comb begin
        total_next = total_reg;
        pend_next  = pend_reg;
        if (retire.valid) begin
            total_next = retire.total;
            pend_next  = 1'b0;
        end else if (accept && resc) begin
            pend_next = 1'b1;
        end else if (accept && act) begin
            total_next = total_reg + TAB_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg   <= MAX_TOTAL_RST;
            total_reg <= TAB_W'(NUM_SYMBOLS);
            pend_reg  <= 1'b0;
        end else begin
            total_reg <= total_next;
            pend_reg  <= pend_next;
            if (cfg_valid && cfg_ready) begin
                max_reg <= cfg_data;
            end
        end
    end

endmodule

### sv/adaptive_cumulative_frequency_model.sv
// adaptive_cumulative_frequency_model: top level, a head stage and a chain of
// table cells. Depends on acfm_pkg, acfm_head and acfm_cell.
//
// Usage: one symbol word on s_valid/s_ready/s_symbol gives one result word on
// m_valid/m_ready with m_cum_high, m_cum_low, m_total and m_rescaled, all as
// the table stood before that symbol was counted. cfg_valid/cfg_ready/cfg_data
// write max_total and is always ready; write it only while the block is idle.
// Each table entry lives in its own cell. A word enters at the top cell and
// moves one cell per cycle while the chain advances, down to cell zero, whose
// stage register drives the result. Words follow each other one per cycle
// while the chain advances and no halving pass is pending; the entry
// increments of several words overlap along the chain. A word that halves
// the counts holds s_ready low until its pass reaches cell zero and the new
// total is known. Reset loads every cell with its initial count at once and
// sets max_total to 16383; no clearing pass is needed. When m_ready is low with
// a result waiting, the whole chain holds and s_ready drops; nothing is lost.
module adaptive_cumulative_frequency_model (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [acfm_pkg::SYM_W-1:0] s_symbol,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [acfm_pkg::TAB_W-1:0] m_cum_high,
    output logic [acfm_pkg::TAB_W-1:0] m_cum_low,
    output logic [acfm_pkg::TAB_W-1:0] m_total,
    output logic                   m_rescaled,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [acfm_pkg::TAB_W-1:0] cfg_data
);
    import acfm_pkg::*;

    wave_t            head_wave;
    wave_t            wave_q  [0:NUM_SYMBOLS];
    logic [TAB_W-1:0] cnt_nx  [0:NUM_SYMBOLS];
    retire_t          retire;
    logic             advance;

    // chain moves whenever the output register is free or being taken
    assign advance = !wave_q[0].valid || m_ready;

    // halving pass done when its word enters cell zero
    assign retire.valid = advance && wave_q[1].valid && wave_q[1].resc;
    assign retire.total = cnt_nx[0];

    acfm_head u_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_symbol  (s_symbol),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .retire    (retire),
        .wave_o    (head_wave)
    );

    // row of cells, word flows from the top index down to zero
    for (genvar i = 0; i <= NUM_SYMBOLS; i++) begin : g_cell
        wave_t            w_in;
        logic [TAB_W-1:0] b_nx;

        if (i == NUM_SYMBOLS) begin : g_top
            assign w_in = head_wave;
        end else begin : g_mid
            assign w_in = wave_q[i+1];
        end

        if (i == 0) begin : g_bot
            assign b_nx = '0;
        end else begin : g_up
            assign b_nx = cnt_nx[i-1];
        end

        acfm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .cell_idx   (IDX_W'(i)),
            .wave_i     (w_in),
            .below_next (b_nx),
            .wave_o     (wave_q[i]),
            .cnt_next_o (cnt_nx[i])
        );
    end

    // result word from the stage register of cell zero
    assign m_valid    = wave_q[0].valid;
    assign m_cum_high = wave_q[0].hi;
    assign m_cum_low  = wave_q[0].lo;
    assign m_total    = wave_q[0].tot;
    assign m_rescaled = wave_q[0].resc;

endmodule
